// ===== src/fqs_pkg.sv =====
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants for the FIFO queue with membership search.
// ----------------------------------------------------------------------------
package fqs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        REQ_ENQ    = 2'd0,
        REQ_DEQ    = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NOP    = 2'd3
    } fqs_req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } fqs_status_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_READ = 5'b00100,
        S_SCAN = 5'b01000,
        S_DONE = 5'b10000
    } fqs_state_t;

    typedef struct packed {
        logic        load_req;
        logic        enq_write;
        logic        head_read;
        logic        deq_pop;
        logic        scan_step;
        logic        set_status;
        fqs_status_t status;
        logic        load_out;
    } fqs_cmd_t;

    typedef struct packed {
        fqs_req_t req;
        logic     full;
        logic     empty;
        logic     scan_last;
        logic     out_free;
    } fqs_stat_t;

endpackage

// ===== src/fifo_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// FIFO queue of words with enqueue, dequeue and membership search requests.
// ----------------------------------------------------------------------------
//  channel  | ports                               | direction
//  request  | s_valid s_ready s_req_type s_word_in | in
//  result   | m_valid m_ready m_word_out m_found   | out
//           | m_status m_is_empty                  |
//
//  One request at a time. Enqueue and no-op pass through the execute and
//  done steps; a dequeue of a non-empty queue adds a read step, and a search
//  of a non-empty queue adds a scan step that compares one stored entry per
//  cycle through the single registered read port of the ring memory.
//  A new request is taken while the previous result sits in the output
//  register; a stalled result holds the sequencer in its final step.
//  Synchronous active-low reset clears pointers and count; no memory sweep.
// ----------------------------------------------------------------------------
module fifo_queue_with_search
    import fqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_req_type,
    input  logic [WIDTH-1:0] s_word_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_word_out,
    output logic             m_found,
    output logic [1:0]       m_status,
    output logic             m_is_empty
);

    fqs_cmd_t  cmd;
    fqs_stat_t stat;

    fqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fqs_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_req_type (s_req_type),
        .s_word_in  (s_word_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word_out (m_word_out),
        .m_found    (m_found),
        .m_status   (m_status),
        .m_is_empty (m_is_empty),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

// ===== src/fqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqs_ctrl
// Request sequencer: decodes each request and steps the datapath.
// ----------------------------------------------------------------------------
module fqs_ctrl
    import fqs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  fqs_stat_t stat,
    output fqs_cmd_t  cmd
);

    fqs_state_t state_reg;
    fqs_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STAT_OK;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (stat.req)
                    REQ_ENQ: begin
                        if (stat.full) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STAT_FULL;
                        end else begin
                            cmd.enq_write = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    REQ_DEQ: begin
                        if (stat.empty) begin
                            cmd.set_status = 1'b1;
                            cmd.status     = STAT_EMPTY;
                            state_next     = S_DONE;
                        end else begin
                            cmd.head_read = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    REQ_SEARCH: begin
                        if (stat.empty) begin
                            state_next = S_DONE;
                        end else begin
                            cmd.head_read = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                cmd.deq_pop = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/fqs_datapath.sv =====
// ----------------------------------------------------------------------------
// fqs_datapath
// Ring storage, pointers, entry count, search compare and result register.
// ----------------------------------------------------------------------------
module fqs_datapath
    import fqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       s_req_type,
    input  logic [WIDTH-1:0] s_word_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_word_out,
    output logic             m_found,
    output logic [1:0]       m_status,
    output logic             m_is_empty,
    input  fqs_cmd_t         cmd,
    output fqs_stat_t        stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    logic [WIDTH-1:0] entry_mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;

    logic [1:0]       req_reg;
    logic [WIDTH-1:0] word_reg;
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    tail_reg;
    logic [AW-1:0]    pos_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    scan_cnt_reg;
    logic [WIDTH-1:0] data_reg;
    logic             hit_reg;
    fqs_status_t      result_stat_reg;
    logic             m_valid_reg;
    logic [WIDTH-1:0] m_word_reg;
    logic             m_found_reg;
    logic [1:0]       m_status_reg;
    logic             m_is_empty_reg;

    assign rd_addr = cmd.head_read ? head_reg : pos_reg;

    always_ff @(posedge aclk) begin
        if (cmd.enq_write) begin
            entry_mem_reg[tail_reg] <= word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.head_read || cmd.scan_step) begin
            rd_data_reg <= entry_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg  <= s_req_type;
            word_reg <= s_word_in;
        end
        if (cmd.head_read) begin
            pos_reg <= ring_next(head_reg);
        end else if (cmd.scan_step) begin
            pos_reg <= ring_next(pos_reg);
        end
        if (cmd.load_req) begin
            data_reg <= '0;
        end else if (cmd.deq_pop) begin
            data_reg <= rd_data_reg;
        end
        if (cmd.load_out) begin
            m_word_reg     <= data_reg;
            m_found_reg    <= hit_reg;
            m_status_reg   <= result_stat_reg;
            m_is_empty_reg <= (count_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            scan_cnt_reg    <= '0;
            hit_reg         <= 1'b0;
            result_stat_reg <= STAT_OK;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cmd.enq_write) begin
                tail_reg  <= ring_next(tail_reg);
                count_reg <= count_reg + 1'b1;
            end else if (cmd.deq_pop) begin
                head_reg  <= ring_next(head_reg);
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.head_read) begin
                scan_cnt_reg <= '0;
            end else if (cmd.scan_step) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (cmd.load_req) begin
                hit_reg <= 1'b0;
            end else if (cmd.scan_step && (rd_data_reg == word_reg)) begin
                hit_reg <= 1'b1;
            end
            if (cmd.load_req) begin
                result_stat_reg <= STAT_OK;
            end else if (cmd.set_status) begin
                result_stat_reg <= cmd.status;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.req       = fqs_req_t'(req_reg);
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.scan_last = (CW'(scan_cnt_reg + 1'b1) == count_reg);
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_word_out = m_word_reg;
    assign m_found    = m_found_reg;
    assign m_status   = m_status_reg;
    assign m_is_empty = m_is_empty_reg;

endmodule

// ===== src/fqs_checker.sv =====
// ----------------------------------------------------------------------------
// fqs_checker
// Port-level checks for the FIFO queue with search, bound to the top level.
// ----------------------------------------------------------------------------
module fqs_checker
    import fqs_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [WIDTH-1:0] m_word_out,
    input logic             m_found,
    input logic [1:0]       m_status,
    input logic             m_is_empty
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_out) && $stable(m_status))
        else $error("result changed while stalled");

    // one request in flight
    a_one_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in progress");

    a_empty_deq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_EMPTY) |-> m_is_empty && (m_word_out == '0))
        else $error("dequeue on empty reports data or non-empty");

    a_full_enq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_FULL) |-> !m_is_empty && !m_found)
        else $error("dropped enqueue with empty or found flag");

    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> (m_status == STAT_OK) && !m_is_empty && (m_word_out == '0))
        else $error("search hit on empty queue or with bad fields");

endmodule

bind fifo_queue_with_search fqs_checker #(
    .WIDTH (WIDTH)
) u_fqs_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_word_out (m_word_out),
    .m_found    (m_found),
    .m_status   (m_status),
    .m_is_empty (m_is_empty)
);
